// ===== design/c8ie_pkg.sv =====
// Shared types, opcode codes and constants for the CHIP-8 instruction execute block.
`timescale 1ns / 1ps

package c8ie_pkg;

   typedef logic [2:0]  action_type;
   typedef logic [3:0]  vreg_index_type;
   typedef logic [7:0]  vreg_data_type;
   typedef logic [15:0] pc_type;

   // Requests to the outside world carried in the result.
   localparam action_type ACT_NONE  = 3'd0;
   localparam action_type ACT_CLEAR = 3'd1;
   localparam action_type ACT_DRAW  = 3'd2;
   localparam action_type ACT_DELAY = 3'd3;
   localparam action_type ACT_SOUND = 3'd4;

   // Instruction groups, selected by the top nibble of the opcode.
   localparam logic [3:0] GRP_SYS       = 4'h0;
   localparam logic [3:0] GRP_JUMP      = 4'h1;
   localparam logic [3:0] GRP_SKEQ_IMM  = 4'h3;
   localparam logic [3:0] GRP_SKNE_IMM  = 4'h4;
   localparam logic [3:0] GRP_SKEQ_REG  = 4'h5;
   localparam logic [3:0] GRP_LOAD_IMM  = 4'h6;
   localparam logic [3:0] GRP_ADD_IMM   = 4'h7;
   localparam logic [3:0] GRP_ALU       = 4'h8;
   localparam logic [3:0] GRP_SKNE_REG  = 4'h9;
   localparam logic [3:0] GRP_SET_INDEX = 4'hA;
   localparam logic [3:0] GRP_DRAW      = 4'hD;
   localparam logic [3:0] GRP_MISC      = 4'hF;

   // Register-to-register operations, selected by the low nibble.
   localparam logic [3:0] ALU_MOVE = 4'h0;
   localparam logic [3:0] ALU_OR   = 4'h1;
   localparam logic [3:0] ALU_AND  = 4'h2;
   localparam logic [3:0] ALU_XOR  = 4'h3;
   localparam logic [3:0] ALU_ADD  = 4'h4;

   // Timer operations, selected by the low byte.
   localparam logic [7:0] MISC_GET_DELAY = 8'h07;
   localparam logic [7:0] MISC_SET_DELAY = 8'h15;
   localparam logic [7:0] MISC_SET_SOUND = 8'h18;

   localparam logic [15:0]    CLEAR_OPCODE = 16'h00E0;
   localparam pc_type         RESET_START  = 16'h0200;
   localparam pc_type         PC_STEP      = 16'd2;
   localparam vreg_index_type V_FLAG       = 4'hF;
   localparam int             VREG_DEPTH   = 16;

endpackage

// ===== design/chip8_instruction_execute.sv =====
// CHIP-8 instruction execute core: decode, V register file, index and program counter.
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_ready   opcode, delay_timer_now, draw_collision
// rsp_      out        rsp_valid/rsp_ready   next_fetch_address, action, sprite_address,
//                                            draw_column, draw_row, sprite_rows, timer_value
// csr_      in         csr_write_enable      start_address (12 bits), also loads the pc
//
// One instruction per cycle sustained while rsp_ready is high; the request transfer
// captures the opcode and the two V register reads into the execute stage register.
// The execute stage updates the registers and the program counter when its result
// moves into the output register, so a stalled result holds the pipeline back.
// Reset clears all V registers, the index register and returns the pc to 0x200;
// the V register file clears through per-entry valid bits, so no clearing pass is needed.

module chip8_instruction_execute (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_opcode,
   input  logic [7:0]  req_delay_timer_now,
   input  logic        req_draw_collision,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_next_fetch_address,
   output logic [2:0]  rsp_action,
   output logic [11:0] rsp_sprite_address,
   output logic [7:0]  rsp_draw_column,
   output logic [7:0]  rsp_draw_row,
   output logic [3:0]  rsp_sprite_rows,
   output logic [7:0]  rsp_timer_value,
   input  logic        csr_write_enable,
   input  logic [11:0] csr_write_data
);

   // Architectural state. VF lives in its own register so the file needs one write port.
   c8ie_pkg::vreg_data_type vmem [c8ie_pkg::VREG_DEPTH];
   logic [c8ie_pkg::VREG_DEPTH-1:0] vvalid_ff, vvalid_in;
   c8ie_pkg::vreg_data_type vf_ff, vf_in;
   logic [11:0]             index_ff, index_in;
   c8ie_pkg::pc_type        pc_ff, pc_in;

   // Execute stage input register.
   logic        ex_valid_ff, ex_valid_in;
   logic [15:0] ex_opcode_ff;
   logic [7:0]  ex_delay_ff;
   logic        ex_coll_ff;

   // Registered file read data with bypass of a same-edge write.
   c8ie_pkg::vreg_data_type rd_x_ff, rd_y_ff, byp_data_ff;
   logic byp_x_ff, byp_y_ff, vld_x_ff, vld_y_ff;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_pc_ff;
   logic [2:0]  rsp_action_ff;
   logic [11:0] rsp_sprite_ff;
   logic [7:0]  rsp_col_ff, rsp_row_ff, rsp_tval_ff;
   logic [3:0]  rsp_rows_ff;

   logic out_free, exec, req_fire;
   c8ie_pkg::vreg_index_type req_x, req_y, ex_x, ex_y;
   logic [3:0]  ex_n;
   logic [7:0]  ex_nn;
   logic [11:0] ex_nnn;
   c8ie_pkg::vreg_data_type vx, vy, vx_file, vy_file;
   logic [8:0]  add_sum;

   // Decoded results of the execute stage.
   c8ie_pkg::pc_type        pc_seq, next_pc;
   logic                    skip, jump;
   c8ie_pkg::action_type    act;
   logic [11:0]             spr_addr;
   logic [7:0]              col, row, tval;
   logic [3:0]              rows;
   logic                    reg_we, carry_we, draw_we, index_we;
   c8ie_pkg::vreg_data_type reg_wdata;
   logic                    mem_we;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign exec      = ex_valid_ff && out_free;
   assign req_ready = !ex_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   assign req_x  = req_opcode[11:8];
   assign req_y  = req_opcode[7:4];
   assign ex_x   = ex_opcode_ff[11:8];
   assign ex_y   = ex_opcode_ff[7:4];
   assign ex_n   = ex_opcode_ff[3:0];
   assign ex_nn  = ex_opcode_ff[7:0];
   assign ex_nnn = ex_opcode_ff[11:0];

   assign vx_file = byp_x_ff ? byp_data_ff : (vld_x_ff ? rd_x_ff : '0);
   assign vy_file = byp_y_ff ? byp_data_ff : (vld_y_ff ? rd_y_ff : '0);
   assign vx      = (ex_x == c8ie_pkg::V_FLAG) ? vf_ff : vx_file;
   assign vy      = (ex_y == c8ie_pkg::V_FLAG) ? vf_ff : vy_file;
   assign add_sum = {1'b0, vx} + {1'b0, vy};

   always_comb begin
      skip      = 1'b0;
      jump      = 1'b0;
      act       = c8ie_pkg::ACT_NONE;
      spr_addr  = '0;
      col       = '0;
      row       = '0;
      rows      = '0;
      tval      = '0;
      reg_we    = 1'b0;
      reg_wdata = vy;
      carry_we  = 1'b0;
      draw_we   = 1'b0;
      index_we  = 1'b0;
      unique case (ex_opcode_ff[15:12])
         c8ie_pkg::GRP_SYS: begin
            if (ex_opcode_ff == c8ie_pkg::CLEAR_OPCODE) begin
               act = c8ie_pkg::ACT_CLEAR;
            end
         end
         c8ie_pkg::GRP_JUMP: begin
            jump = 1'b1;
         end
         c8ie_pkg::GRP_SKEQ_IMM: begin
            skip = (vx == ex_nn);
         end
         c8ie_pkg::GRP_SKNE_IMM: begin
            skip = (vx != ex_nn);
         end
         c8ie_pkg::GRP_SKEQ_REG: begin
            skip = (ex_n == 4'h0) && (vx == vy);
         end
         c8ie_pkg::GRP_LOAD_IMM: begin
            reg_we    = 1'b1;
            reg_wdata = ex_nn;
         end
         c8ie_pkg::GRP_ADD_IMM: begin
            reg_we    = 1'b1;
            reg_wdata = vx + ex_nn;
         end
         c8ie_pkg::GRP_ALU: begin
            unique case (ex_n)
               c8ie_pkg::ALU_MOVE: begin
                  reg_we    = 1'b1;
                  reg_wdata = vy;
               end
               c8ie_pkg::ALU_OR: begin
                  reg_we    = 1'b1;
                  reg_wdata = vx | vy;
               end
               c8ie_pkg::ALU_AND: begin
                  reg_we    = 1'b1;
                  reg_wdata = vx & vy;
               end
               c8ie_pkg::ALU_XOR: begin
                  reg_we    = 1'b1;
                  reg_wdata = vx ^ vy;
               end
               c8ie_pkg::ALU_ADD: begin
                  reg_we    = 1'b1;
                  reg_wdata = add_sum[7:0];
                  carry_we  = 1'b1;
               end
               default: begin
               end
            endcase
         end
         c8ie_pkg::GRP_SKNE_REG: begin
            skip = (ex_n == 4'h0) && (vx != vy);
         end
         c8ie_pkg::GRP_SET_INDEX: begin
            index_we = 1'b1;
         end
         c8ie_pkg::GRP_DRAW: begin
            act      = c8ie_pkg::ACT_DRAW;
            spr_addr = index_ff;
            col      = vx;
            row      = vy;
            rows     = ex_n;
            draw_we  = 1'b1;
         end
         c8ie_pkg::GRP_MISC: begin
            unique case (ex_nn)
               c8ie_pkg::MISC_GET_DELAY: begin
                  reg_we    = 1'b1;
                  reg_wdata = ex_delay_ff;
               end
               c8ie_pkg::MISC_SET_DELAY: begin
                  act  = c8ie_pkg::ACT_DELAY;
                  tval = vx;
               end
               c8ie_pkg::MISC_SET_SOUND: begin
                  act  = c8ie_pkg::ACT_SOUND;
                  tval = vx;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase

      pc_seq = pc_ff + c8ie_pkg::PC_STEP;
      if (jump) begin
         next_pc = {4'b0, ex_nnn};
      end else if (skip) begin
         next_pc = pc_seq + c8ie_pkg::PC_STEP;
      end else begin
         next_pc = pc_seq;
      end
   end

   assign mem_we = exec && reg_we && (ex_x != c8ie_pkg::V_FLAG);

   always_comb begin
      vvalid_in = vvalid_ff;
      if (mem_we) begin
         vvalid_in[ex_x] = 1'b1;
      end

      // The carry and the collision flag win over an ordinary write of VF.
      vf_in = vf_ff;
      if (exec) begin
         if (carry_we) begin
            vf_in = {7'b0, add_sum[8]};
         end else if (draw_we) begin
            vf_in = {7'b0, ex_coll_ff};
         end else if (reg_we && (ex_x == c8ie_pkg::V_FLAG)) begin
            vf_in = reg_wdata;
         end
      end

      index_in = index_ff;
      if (exec && index_we) begin
         index_in = ex_nnn;
      end

      pc_in = pc_ff;
      if (csr_write_enable) begin
         pc_in = {4'b0, csr_write_data};
      end else if (exec) begin
         pc_in = next_pc;
      end

      ex_valid_in = ex_valid_ff;
      if (req_fire) begin
         ex_valid_in = 1'b1;
      end else if (exec) begin
         ex_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // V register file: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         vmem[ex_x] <= reg_wdata;
      end
      if (req_fire) begin
         rd_x_ff     <= vmem[req_x];
         rd_y_ff     <= vmem[req_y];
         byp_data_ff <= reg_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vvalid_ff   <= '0;
         vf_ff       <= '0;
         index_ff    <= '0;
         pc_ff       <= c8ie_pkg::RESET_START;
         ex_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         byp_x_ff    <= 1'b0;
         byp_y_ff    <= 1'b0;
         vld_x_ff    <= 1'b0;
         vld_y_ff    <= 1'b0;
      end else begin
         vvalid_ff    <= vvalid_in;
         vf_ff        <= vf_in;
         index_ff     <= index_in;
         pc_ff        <= pc_in;
         ex_valid_ff  <= ex_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            // A write landing on the address being read is taken from the bypass.
            byp_x_ff <= mem_we && (ex_x == req_x);
            byp_y_ff <= mem_we && (ex_x == req_y);
            vld_x_ff <= vvalid_ff[req_x];
            vld_y_ff <= vvalid_ff[req_y];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ex_opcode_ff <= req_opcode;
         ex_delay_ff  <= req_delay_timer_now;
         ex_coll_ff   <= req_draw_collision;
      end
      if (exec) begin
         rsp_pc_ff     <= next_pc;
         rsp_action_ff <= act;
         rsp_sprite_ff <= spr_addr;
         rsp_col_ff    <= col;
         rsp_row_ff    <= row;
         rsp_rows_ff   <= rows;
         rsp_tval_ff   <= tval;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_next_fetch_address = rsp_pc_ff;
   assign rsp_action             = rsp_action_ff;
   assign rsp_sprite_address     = rsp_sprite_ff;
   assign rsp_draw_column        = rsp_col_ff;
   assign rsp_draw_row           = rsp_row_ff;
   assign rsp_sprite_rows        = rsp_rows_ff;
   assign rsp_timer_value        = rsp_tval_ff;

endmodule

// ===== design/c8ie_checker.sv =====
// Port-level assertions for the CHIP-8 instruction execute block, with its bind.
`timescale 1ns / 1ps

module c8ie_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [15:0] req_opcode,
   input logic [7:0]  req_delay_timer_now,
   input logic        req_draw_collision,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_next_fetch_address,
   input logic [2:0]  rsp_action,
   input logic [11:0] rsp_sprite_address,
   input logic [7:0]  rsp_draw_column,
   input logic [7:0]  rsp_draw_row,
   input logic [3:0]  rsp_sprite_rows,
   input logic [7:0]  rsp_timer_value,
   input logic        csr_write_enable,
   input logic [11:0] csr_write_data
);

   // A stalled result keeps its contents until the transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_fetch_address)
         && $stable(rsp_action) && $stable(rsp_timer_value))
      else $error("result changed while stalled");

   a_action_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_action <= c8ie_pkg::ACT_SOUND)
      else $error("illegal action code");

   a_draw_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != c8ie_pkg::ACT_DRAW |->
         rsp_sprite_address == '0 && rsp_draw_column == '0 && rsp_draw_row == '0
         && rsp_sprite_rows == '0)
      else $error("draw fields set on a non-draw result");

   a_timer_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != c8ie_pkg::ACT_DELAY && rsp_action != c8ie_pkg::ACT_SOUND
         |-> rsp_timer_value == '0)
      else $error("timer value set on a non-timer result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind chip8_instruction_execute c8ie_checker u_c8ie_checker (.*);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the CHIP-8 instruction execute core.
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_LIMIT  = 10;
   localparam int IDLE_PERCENT  = 32;
   localparam int SETTLE_CYCLES = 4;

   typedef struct packed {
      logic [15:0]          opcode;
      c8ie_pkg::pc_type     next_pc;
      c8ie_pkg::action_type action;
      logic [11:0]          sprite_addr;
      logic [7:0]           column;
      logic [7:0]           row;
      logic [3:0]           rows;
      logic [7:0]           timer;
   } instr_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_opcode;
   logic [7:0]  req_delay_timer_now;
   logic        req_draw_collision;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_next_fetch_address;
   logic [2:0]  rsp_action;
   logic [11:0] rsp_sprite_address;
   logic [7:0]  rsp_draw_column;
   logic [7:0]  rsp_draw_row;
   logic [3:0]  rsp_sprite_rows;
   logic [7:0]  rsp_timer_value;
   logic        csr_write_enable;
   logic [11:0] csr_write_data;

   // Shadow copy of the architectural state.
   c8ie_pkg::vreg_data_type gpr [c8ie_pkg::VREG_DEPTH];
   logic [11:0]             index_reg;
   c8ie_pkg::pc_type        prog_counter;
   logic [11:0]             start_addr;

   instr_result_type expected_results [$];
   bit               no_idle = 1'b0;
   int               failure_count = 0;
   int               instr_count = 0;
   int               result_count = 0;
   int               csr_writes = 0;
   int               cycle_count = 0;

   chip8_instruction_execute i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_opcode             (req_opcode),
      .req_delay_timer_now    (req_delay_timer_now),
      .req_draw_collision     (req_draw_collision),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_next_fetch_address (rsp_next_fetch_address),
      .rsp_action             (rsp_action),
      .rsp_sprite_address     (rsp_sprite_address),
      .rsp_draw_column        (rsp_draw_column),
      .rsp_draw_row           (rsp_draw_row),
      .rsp_sprite_rows        (rsp_sprite_rows),
      .rsp_timer_value        (rsp_timer_value),
      .csr_write_enable       (csr_write_enable),
      .csr_write_data         (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Executes one instruction on the shadow state and returns what the block should report.
   function automatic instr_result_type execute_instr(input logic [15:0] op,
                                                      input logic [7:0] dt,
                                                      input logic coll);
      instr_result_type         res;
      c8ie_pkg::vreg_index_type x;
      c8ie_pkg::vreg_index_type y;
      logic [3:0]               n;
      logic [7:0]               nn;
      c8ie_pkg::vreg_data_type  vx;
      c8ie_pkg::vreg_data_type  vy;
      logic [8:0]               sum;
      c8ie_pkg::pc_type         next;
      bit                       skip;
      x    = op[11:8];
      y    = op[7:4];
      n    = op[3:0];
      nn   = op[7:0];
      vx   = gpr[x];
      vy   = gpr[y];
      res  = '0;
      res.opcode = op;
      res.action = c8ie_pkg::ACT_NONE;
      next = prog_counter + c8ie_pkg::PC_STEP;
      skip = 1'b0;
      case (op[15:12])
         c8ie_pkg::GRP_SYS:
            if (op == c8ie_pkg::CLEAR_OPCODE) res.action = c8ie_pkg::ACT_CLEAR;
         c8ie_pkg::GRP_JUMP:      next = {4'h0, op[11:0]};
         c8ie_pkg::GRP_SKEQ_IMM:  skip = (vx == nn);
         c8ie_pkg::GRP_SKNE_IMM:  skip = (vx != nn);
         c8ie_pkg::GRP_SKEQ_REG:  if (n == 4'h0) skip = (vx == vy);
         c8ie_pkg::GRP_LOAD_IMM:  gpr[x] = nn;
         c8ie_pkg::GRP_ADD_IMM:   gpr[x] = vx + nn;
         c8ie_pkg::GRP_ALU: begin
            case (n)
               c8ie_pkg::ALU_MOVE: gpr[x] = vy;
               c8ie_pkg::ALU_OR:   gpr[x] = vx | vy;
               c8ie_pkg::ALU_AND:  gpr[x] = vx & vy;
               c8ie_pkg::ALU_XOR:  gpr[x] = vx ^ vy;
               c8ie_pkg::ALU_ADD: begin
                  // The carry lands in VF after the sum, so it wins when X is VF.
                  sum                   = {1'b0, vx} + {1'b0, vy};
                  gpr[x]                = sum[7:0];
                  gpr[c8ie_pkg::V_FLAG] = {7'd0, sum[8]};
               end
               default: ;
            endcase
         end
         c8ie_pkg::GRP_SKNE_REG:  if (n == 4'h0) skip = (vx != vy);
         c8ie_pkg::GRP_SET_INDEX: index_reg = op[11:0];
         c8ie_pkg::GRP_DRAW: begin
            res.action            = c8ie_pkg::ACT_DRAW;
            res.sprite_addr       = index_reg;
            res.column            = vx;
            res.row               = vy;
            res.rows              = n;
            gpr[c8ie_pkg::V_FLAG] = {7'd0, coll};
         end
         c8ie_pkg::GRP_MISC: begin
            case (nn)
               c8ie_pkg::MISC_GET_DELAY: gpr[x] = dt;
               c8ie_pkg::MISC_SET_DELAY: begin
                  res.action = c8ie_pkg::ACT_DELAY;
                  res.timer  = vx;
               end
               c8ie_pkg::MISC_SET_SOUND: begin
                  res.action = c8ie_pkg::ACT_SOUND;
                  res.timer  = vx;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      if (skip) next = next + c8ie_pkg::PC_STEP;
      prog_counter = next;
      res.next_pc  = next;
      return res;
   endfunction

   always @(posedge clock) begin
      instr_result_type exp;
      if (!reset && rsp_valid && rsp_ready) begin
         result_count <= result_count + 1;
         if (expected_results.size() == 0) begin
            failure_count = failure_count + 1;
            if (failure_count <= REPORT_LIMIT)
               $display("Unexpected result: pc %h action %0d", rsp_next_fetch_address,
                        rsp_action);
         end else begin
            exp = expected_results.pop_front();
            if (rsp_next_fetch_address !== exp.next_pc || rsp_action !== exp.action ||
                rsp_sprite_address !== exp.sprite_addr || rsp_draw_column !== exp.column ||
                rsp_draw_row !== exp.row || rsp_sprite_rows !== exp.rows ||
                rsp_timer_value !== exp.timer) begin
               failure_count = failure_count + 1;
               if (failure_count <= REPORT_LIMIT) begin
                  $display("Mismatch for opcode %h:", exp.opcode);
                  $display("  expected pc %h act %0d spr %h col %h row %h n %h tim %h",
                           exp.next_pc, exp.action, exp.sprite_addr, exp.column, exp.row,
                           exp.rows, exp.timer);
                  $display("  actual   pc %h act %0d spr %h col %h row %h n %h tim %h",
                           rsp_next_fetch_address, rsp_action, rsp_sprite_address,
                           rsp_draw_column, rsp_draw_row, rsp_sprite_rows, rsp_timer_value);
               end
            end
         end
      end
   end

   // Presents one instruction and records its expected result at the transfer.
   task automatic send_instr(input logic [15:0] op, input logic [7:0] dt, input logic coll);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_opcode          <= op;
      req_delay_timer_now <= dt;
      req_draw_collision  <= coll;
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(execute_instr(op, dt, coll));
      instr_count = instr_count + 1;
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_start_address(input logic [11:0] value);
      wait_drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      start_addr   = value;
      prog_counter = {4'h0, value};
      csr_writes   = csr_writes + 1;
   endtask

   // Mostly well-formed instructions, biased so that skips are taken about half the time.
   function automatic logic [15:0] pick_opcode();
      logic [3:0]  x;
      logic [3:0]  y;
      logic [3:0]  n;
      logic [7:0]  nn;
      logic [15:0] op;
      x  = 4'($urandom_range(0, 15));
      y  = ($urandom_range(0, 3) == 0) ? x : 4'($urandom_range(0, 15));
      n  = 4'($urandom_range(0, 15));
      nn = $urandom_range(0, 1) ? gpr[x] : 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 8) begin
         op = 16'($urandom_range(0, 65535));
      end else begin
         case ($urandom_range(0, 13))
            0:  op = ($urandom_range(0, 3) == 0) ? {c8ie_pkg::GRP_SYS, x, nn} :
                                                   c8ie_pkg::CLEAR_OPCODE;
            1:  op = {c8ie_pkg::GRP_JUMP, x, nn};
            2:  op = {c8ie_pkg::GRP_SKEQ_IMM, x, nn};
            3:  op = {c8ie_pkg::GRP_SKNE_IMM, x, nn};
            4:  op = {c8ie_pkg::GRP_SKEQ_REG, x, y, ($urandom_range(0, 7) == 0) ? n : 4'h0};
            5:  op = {c8ie_pkg::GRP_LOAD_IMM, x, nn};
            6:  op = {c8ie_pkg::GRP_ADD_IMM, x, nn};
            7, 8: op = {c8ie_pkg::GRP_ALU, x, y, ($urandom_range(0, 7) == 0) ? n :
                        4'($urandom_range(c8ie_pkg::ALU_MOVE, c8ie_pkg::ALU_ADD))};
            9:  op = {c8ie_pkg::GRP_SKNE_REG, x, y, ($urandom_range(0, 7) == 0) ? n : 4'h0};
            10: op = {c8ie_pkg::GRP_SET_INDEX, x, nn};
            11: op = {c8ie_pkg::GRP_DRAW, x, y, n};
            default: begin
               case ($urandom_range(0, 3))
                  0: op = {c8ie_pkg::GRP_MISC, x, c8ie_pkg::MISC_GET_DELAY};
                  1: op = {c8ie_pkg::GRP_MISC, x, c8ie_pkg::MISC_SET_DELAY};
                  2: op = {c8ie_pkg::GRP_MISC, x, c8ie_pkg::MISC_SET_SOUND};
                  default: op = {c8ie_pkg::GRP_MISC, x, nn};
               endcase
            end
         endcase
      end
      return op;
   endfunction

   task automatic run_random_program(input int count);
      repeat (count)
         send_instr(pick_opcode(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   task automatic test_directed();
      send_instr(c8ie_pkg::CLEAR_OPCODE, 8'h00, 1'b0);
      send_instr(16'h0123, 8'h00, 1'b0);       // system call other than clear
      send_instr(16'h60FF, 8'h00, 1'b0);
      send_instr(16'h61FF, 8'h00, 1'b0);
      send_instr(16'h8014, 8'h00, 1'b0);       // carry out of the add
      send_instr(16'h7002, 8'h00, 1'b0);       // immediate add wraps to zero
      send_instr(16'h3000, 8'h00, 1'b0);
      send_instr(16'h3001, 8'h00, 1'b0);
      send_instr(16'h40FF, 8'h00, 1'b0);
      send_instr(16'h5000, 8'h00, 1'b0);
      send_instr(16'h5011, 8'h00, 1'b0);       // register skip with nonzero low nibble
      send_instr(16'h9010, 8'h00, 1'b0);
      send_instr(16'h9011, 8'h00, 1'b0);
      send_instr(16'h8211, 8'h00, 1'b0);
      send_instr(16'h8122, 8'h00, 1'b0);
      send_instr(16'h8313, 8'h00, 1'b0);
      send_instr(16'h6FFF, 8'h00, 1'b0);
      send_instr(16'h8FF4, 8'h00, 1'b0);       // add into VF keeps only the carry
      send_instr(16'h801F, 8'h00, 1'b0);
      send_instr(16'hAFFF, 8'h00, 1'b0);
      send_instr(16'hDF1F, 8'h00, 1'b1);       // draw reports VF before the collision lands
      send_instr(16'hF007, 8'hFF, 1'b0);
      send_instr(16'hF015, 8'h00, 1'b0);
      send_instr(16'hF318, 8'h00, 1'b0);
      send_instr(16'hE09E, 8'h00, 1'b0);
      send_instr(16'h1FFF, 8'h00, 1'b0);
      send_instr(16'h1000, 8'h00, 1'b0);
   endtask

   task automatic test_start_address_extremes();
      write_start_address(12'hFFF);
      run_random_program(6);
      write_start_address(12'h000);
      run_random_program(6);
   endtask

   task automatic test_random_programs();
      write_start_address(12'($urandom_range(0, 4095)));
      run_random_program(240);
      write_start_address(12'hFFF);
      run_random_program(240);
      write_start_address(12'h000);
      run_random_program(240);
      write_start_address(12'(c8ie_pkg::RESET_START));
      run_random_program(240);
   endtask

   // Back-to-back transfers on both channels.
   task automatic test_full_rate();
      wait_drain();
      no_idle = 1'b1;
      run_random_program(200);
      wait_drain();
      no_idle = 1'b0;
   endtask

   initial begin
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_opcode          <= 16'h0000;
      req_delay_timer_now <= 8'h00;
      req_draw_collision  <= 1'b0;
      csr_write_enable    <= 1'b0;
      csr_write_data      <= 12'h000;
      foreach (gpr[k]) gpr[k] = 8'h00;
      index_reg    = 12'h000;
      start_addr   = 12'(c8ie_pkg::RESET_START);
      prog_counter = c8ie_pkg::RESET_START;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_start_address_extremes();
      test_random_programs();
      test_full_rate();

      wait_drain();
      repeat (10) @(posedge clock);
      failure_count = failure_count + expected_results.size();
      $display("Executed %0d instructions, checked %0d results, %0d start-address writes.",
               instr_count, result_count, csr_writes);
      $display("Covered all opcode groups, skips, carries, draws, timers and stalls.");
      if (failure_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== chip8_instruction_execute.f =====
design/c8ie_pkg.sv
design/chip8_instruction_execute.sv
design/c8ie_checker.sv
tb/sv/tb.sv
